// ----- design/heading_angle_degrees_macros.svh -----
// Assertion macros shared by the heading angle design.
`ifndef HEADING_ANGLE_DEGREES_MACROS_SVH
`define HEADING_ANGLE_DEGREES_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HDG_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define HDG_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/hdg_pkg.sv -----
// Shared constants, arctangent table and stage word type for the heading angle pipeline.
package hdg_pkg;

    // Fixed widths of the datapath and the result.
    localparam int DP_W      = 64;
    localparam int ANG_W     = 32;
    localparam int TAB_SIZE  = 24;
    localparam int HEADING_W = 16;

    // Differences are aligned so that their top lands just below this bit.
    localparam int DIFF_ALIGN = 59;

    localparam int DEGREES_PER_TURN = 360;

    // Defaults for the top level parameters.
    localparam int COORD_WIDTH_DEF     = 24;
    localparam int CORDIC_STEPS_DEF    = 16;
    localparam int ANGLE_FRAC_BITS_DEF = 7;

    // Half a turn in binary angle units; also half an LSB of the scaled result.
    localparam logic [ANG_W-1:0] HALF_TURN = 32'h8000_0000;

    // round(atan(2^-i) * 2^32 / (2*pi)) for each iteration.
    localparam logic [ANG_W-1:0] ATAN_TAB [TAB_SIZE] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    // One word in flight through the rotation stages.
    typedef struct packed {
        logic signed [DP_W-1:0] cx;
        logic signed [DP_W-1:0] cy;
        logic [ANG_W-1:0]       theta;
        logic                   zero;
    } t_vec;

endpackage

// ----- design/hdg_front.sv -----
// Front end: coordinate differences, alignment and half-plane fold.
module hdg_front
    import hdg_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic signed [COORD_WIDTH-1:0] i_from_x,
    input  logic signed [COORD_WIDTH-1:0] i_from_y,
    input  logic signed [COORD_WIDTH-1:0] i_to_x,
    input  logic signed [COORD_WIDTH-1:0] i_to_y,
    output t_vec                          o_vec
);

    localparam int DIFF_W   = COORD_WIDTH + 1;
    localparam int PRESHIFT = DIFF_ALIGN - COORD_WIDTH;

    logic signed [DIFF_W-1:0] r_dx;
    logic signed [DIFF_W-1:0] r_dy;
    logic                     r_zero;
    logic signed [DIFF_W-1:0] n_dx;
    logic signed [DIFF_W-1:0] n_dy;
    logic                     n_zero;
    logic signed [DP_W-1:0]   w_cx;
    logic signed [DP_W-1:0]   w_cy;
    t_vec                     n_vec;
    t_vec                     r_vec;

    // Full-width differences; equal points are detected on the raw inputs.
    always_comb begin
        n_dx   = DIFF_W'(i_to_x) - DIFF_W'(i_from_x);
        n_dy   = DIFF_W'(i_to_y) - DIFF_W'(i_from_y);
        n_zero = (i_to_x == i_from_x) && (i_to_y == i_from_y);
    end

    // Align into the wide datapath. The rotation frame carries dy in x and dx in y.
    // A vector in the lower half plane is negated and starts at half a turn.
    always_comb begin
        w_cx        = DP_W'(r_dy) <<< PRESHIFT;
        w_cy        = DP_W'(r_dx) <<< PRESHIFT;
        n_vec.zero  = r_zero;
        if (w_cx[DP_W-1]) begin
            n_vec.cx    = -w_cx;
            n_vec.cy    = -w_cy;
            n_vec.theta = HALF_TURN;
        end else begin
            n_vec.cx    = w_cx;
            n_vec.cy    = w_cy;
            n_vec.theta = '0;
        end
    end

    // Two register stages, both held while the pipeline is stalled.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dx   <= n_dx;
            r_dy   <= n_dy;
            r_zero <= n_zero;
            r_vec  <= n_vec;
        end
    end

    assign o_vec = r_vec;

endmodule

// ----- design/hdg_cordic_step.sv -----
// One registered vectoring iteration of the rotation pipeline.
module hdg_cordic_step
    import hdg_pkg::*;
#(
    parameter int STEP = 0
) (
    input  logic i_clk,
    input  logic i_en,
    input  t_vec i_vec,
    output t_vec o_vec
);

    logic signed [DP_W-1:0] w_sx;
    logic signed [DP_W-1:0] w_sy;
    t_vec                   n_vec;
    t_vec                   r_vec;

    // Rotate toward the x axis; the sign of y picks the direction.
    always_comb begin
        w_sx       = $signed(i_vec.cx) >>> STEP;
        w_sy       = $signed(i_vec.cy) >>> STEP;
        n_vec.zero = i_vec.zero;
        if (!i_vec.cy[DP_W-1]) begin
            n_vec.cx    = i_vec.cx + w_sy;
            n_vec.cy    = i_vec.cy - w_sx;
            n_vec.theta = i_vec.theta + ATAN_TAB[STEP];
        end else begin
            n_vec.cx    = i_vec.cx - w_sy;
            n_vec.cy    = i_vec.cy + w_sx;
            n_vec.theta = i_vec.theta - ATAN_TAB[STEP];
        end
    end

    // Stage register.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_vec <= n_vec;
        end
    end

    assign o_vec = r_vec;

endmodule

// ----- design/hdg_back.sv -----
// Back end: binary angle to degrees, rounding and wrap of a full turn.
module hdg_back
    import hdg_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  t_vec                 i_vec,
    output logic [HEADING_W-1:0] o_heading
);

    localparam int FULL_TURN = DEGREES_PER_TURN << ANGLE_FRAC_BITS;
    localparam int TURN_W    = $clog2(FULL_TURN + 1);
    localparam int PROD_W    = ANG_W + TURN_W;

    logic [PROD_W-1:0]    r_prod;
    logic                 r_zero;
    logic [PROD_W-1:0]    w_sum;
    logic [TURN_W-1:0]    w_h;
    logic [HEADING_W-1:0] n_heading;
    logic [HEADING_W-1:0] r_heading;

    // Round half up, drop the binary angle fraction, and give zero for a full turn or for equal points.
    always_comb begin
        w_sum = r_prod + PROD_W'(HALF_TURN);
        w_h   = w_sum[PROD_W-1:ANG_W];
        if (r_zero || (w_h >= TURN_W'(FULL_TURN))) begin
            n_heading = '0;
        end else begin
            n_heading = HEADING_W'(w_h);
        end
    end

    // Multiply by the turn size in one stage, finish the result in the next.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod    <= PROD_W'(i_vec.theta) * PROD_W'(FULL_TURN);
            r_zero    <= i_vec.zero;
            r_heading <= n_heading;
        end
    end

    assign o_heading = r_heading;

endmodule

// ----- design/heading_angle_degrees.sv -----
// Top level of the heading angle pipeline.
//
// Usage: an input word is a pair of points (from, to) in signed Q16.8. It is
// accepted when i_in_valid and o_in_ready are both high. Each result word
// carries o_heading, the clockwise angle from +y toward the second point, in
// units of 1/128 degree (0 .. 46079); equal points give zero.
// Throughput: one word per cycle, back to back, with no bubbles unless the
// output stalls. Pipeline: from acceptance to o_out_valid a word passes two
// front-end stages, one register per rotation iteration, and two stages for
// the degree scaling multiply and the rounding.
// Reset: i_rst_n low at a clock edge clears every valid bit, also that of the
// output holding register; words in flight are dropped.
// Stall: when i_out_ready is low, the word at the output moves into a
// one-entry holding register while the pipeline still advances once. With
// that register full, o_in_ready drops and the whole pipeline holds still
// until the held word is taken. Nothing is lost or repeated.
module heading_angle_degrees
    import hdg_pkg::*;
#(
    parameter int COORD_WIDTH     = COORD_WIDTH_DEF,
    parameter int CORDIC_STEPS    = CORDIC_STEPS_DEF,
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [COORD_WIDTH-1:0] i_from_x,
    input  logic signed [COORD_WIDTH-1:0] i_from_y,
    input  logic signed [COORD_WIDTH-1:0] i_to_x,
    input  logic signed [COORD_WIDTH-1:0] i_to_y,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [HEADING_W-1:0]          o_heading
);

`include "heading_angle_degrees_macros.svh"

    localparam int N_ITER    = (CORDIC_STEPS > TAB_SIZE) ? TAB_SIZE : CORDIC_STEPS;
    localparam int NS        = N_ITER + 4;
    localparam int FULL_TURN = DEGREES_PER_TURN << ANGLE_FRAC_BITS;
    localparam bit FT_FITS   = (FULL_TURN <= (1 << HEADING_W));

    logic [NS-1:0]        r_vld;
    logic [NS-1:0]        n_vld;
    logic                 r_skid_v;
    logic                 n_skid_v;
    logic [HEADING_W-1:0] r_skid_heading;
    logic                 w_en;
    logic [HEADING_W-1:0] w_heading;
    t_vec                 w_vec [N_ITER+1];

    // The pipeline advances as a whole while the holding register is empty.
    assign w_en       = !r_skid_v;
    assign o_in_ready = w_en;

    // Valid bits shift along with the data words.
    always_comb begin
        n_vld    = r_vld;
        n_skid_v = r_skid_v;
        if (w_en) begin
            n_vld = {r_vld[NS-2:0], i_in_valid};
        end
        if (r_skid_v) begin
            n_skid_v = !i_out_ready;
        end else begin
            n_skid_v = r_vld[NS-1] && !i_out_ready;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_skid_v <= 1'b0;
        end else begin
            r_vld    <= n_vld;
            r_skid_v <= n_skid_v;
        end
    end

    // Catch the output word when the receiver stalls.
    always_ff @(posedge i_clk) begin
        if (!r_skid_v && r_vld[NS-1] && !i_out_ready) begin
            r_skid_heading <= w_heading;
        end
    end

    assign o_out_valid = r_skid_v || r_vld[NS-1];
    assign o_heading   = r_skid_v ? r_skid_heading : w_heading;

    // Differences, alignment and half-plane fold.
    hdg_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_from_x (i_from_x),
        .i_from_y (i_from_y),
        .i_to_x   (i_to_x),
        .i_to_y   (i_to_y),
        .o_vec    (w_vec[0])
    );

    // One register stage per rotation iteration.
    for (genvar k = 0; k < N_ITER; k++) begin : g_step
        hdg_cordic_step #(
            .STEP (k)
        ) u_step (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_vec (w_vec[k]),
            .o_vec (w_vec[k+1])
        );
    end

    // Scaling to degrees and rounding.
    hdg_back #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_en      (w_en),
        .i_vec     (w_vec[N_ITER]),
        .o_heading (w_heading)
    );

    // A result never reaches a full turn when the turn fits the output width.
    `HDG_ASSERT_NOW(a_heading_range, i_clk, i_rst_n, o_out_valid, (!FT_FITS) || (int'(o_heading) < FULL_TURN), "heading out of range")

    // An accepted word occupies the first stage in the next cycle.
    `HDG_ASSERT_NXT(a_accept_enters, i_clk, i_rst_n, i_in_valid && o_in_ready, r_vld[0], "accepted word lost at entry")

    // A stalled output word is caught by the holding register.
    `HDG_ASSERT_NXT(a_skid_catch, i_clk, i_rst_n, !r_skid_v && r_vld[NS-1] && !i_out_ready, r_skid_v, "stalled word not held")

    // A held word that is taken frees the holding register.
    `HDG_ASSERT_NXT(a_skid_drain, i_clk, i_rst_n, r_skid_v && i_out_ready, !r_skid_v, "holding register not released")

endmodule
